// File: rtl/wmfp_pkg.sv
`default_nettype none
package wmfp_pkg;

   localparam int SSID_MAX_BYTES      = 32;
   localparam int SSID_ELEMENT_OFFSET = 36;

   localparam int POS_W      = 7;
   localparam int LEN_W      = 6;
   localparam int ADDR_BYTES = 6;
   localparam int SSID_IDX_W = (SSID_MAX_BYTES > 1) ? $clog2(SSID_MAX_BYTES) : 1;
   // one bank per descriptor queue slot
   localparam int MEM_AW     = SSID_IDX_W + 1;
   localparam int MEM_DEPTH  = 2 ** MEM_AW;
   localparam int OUT_DEPTH  = 4;
   localparam int OUT_AW     = 2;

   localparam logic [POS_W-1:0] POS_MAX        = '1;
   localparam logic [7:0]       FC_MASK        = 8'hFC;
   localparam logic [7:0]       FC_PROBE       = 8'h40;
   localparam logic [7:0]       FC_BEACON      = 8'h80;
   localparam logic [POS_W-1:0] PROBE_ADDR_AT  = 7'd10;
   localparam logic [POS_W-1:0] BEACON_ADDR_AT = 7'd16;
   localparam logic [7:0]       SSID_ELEMENT_ID = 8'h00;

   localparam logic [POS_W-1:0] SSID_ID_POS   = POS_W'(SSID_ELEMENT_OFFSET);
   localparam logic [POS_W-1:0] SSID_LEN_POS  = POS_W'(SSID_ELEMENT_OFFSET + 1);
   localparam logic [POS_W-1:0] SSID_TEXT_POS = POS_W'(SSID_ELEMENT_OFFSET + 2);
   localparam logic [POS_W-1:0] SSID_END_POS  =
      POS_W'(SSID_ELEMENT_OFFSET + 2 + SSID_MAX_BYTES);

   typedef enum logic {
      ITEM_DESC = 1'b0,
      ITEM_SSID = 1'b1
   } item_kind_type;

   typedef enum logic {
      KIND_PROBE  = 1'b0,
      KIND_BEACON = 1'b1
   } frame_kind_type;

   typedef struct packed {
      frame_kind_type     frame_kind;
      logic [47:0]        station_address;
      logic signed [7:0]  signal_strength;
      logic [LEN_W-1:0]   ssid_length;
   } desc_type;

   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
      logic [7:0]        data;
   } ssid_wr_type;

   typedef struct packed {
      item_kind_type      item_type;
      frame_kind_type     frame_kind;
      logic [47:0]        station_address;
      logic signed [7:0]  signal_strength;
      logic [LEN_W-1:0]   ssid_length;
      logic [7:0]         ssid_byte;
      logic               last_result;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/wifi_mgmt_frame_parser.sv
// Management frame parser: takes captured 802.11 frames one byte per beat and
// returns a descriptor per probe request or beacon, followed by the SSID text
// bytes of a beacon that carries a complete SSID element.
// Input side: present a byte with push; it is taken on a clock edge where
// push is high and full is low. end_of_frame marks the last byte of a frame.
// Result side: while empty is low the oldest result is on the rsp_ ports;
// pop takes it. last_result marks the final result of a frame.
// Throughput: one byte per cycle, as long as fewer than two finished frames
// wait to be emitted; the two-entry descriptor queue and its two SSID banks
// set that limit, and full stays high while both hold a frame. Results leave
// at one per cycle while pop is held high, 1 + SSID length results per frame.
// The descriptor enters the queue at the edge that takes the last byte of its
// frame; it then passes the issue register and the output buffer to the ports.
// A stalled result side fills the output buffer, then the queue, then raises
// full; nothing is dropped. Reset drops any frame in progress and all queued
// results; the SSID buffer is not cleared.
`default_nettype none
module wifi_mgmt_frame_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire logic [7:0]        req_frame_byte,
   input  wire logic              req_is_management,
   input  wire logic signed [7:0] req_signal_level,
   input  wire logic              req_end_of_frame,
   input  wire logic              pop,
   output logic                   empty,
   output logic                   rsp_item_type,
   output logic                   rsp_frame_kind,
   output logic [47:0]            rsp_station_address,
   output logic signed [7:0]      rsp_signal_strength,
   output logic [5:0]             rsp_ssid_length,
   output logic [7:0]             rsp_ssid_byte,
   output logic                   rsp_last_result
);

   logic                  accept, q_full, wr_slot, rd_slot;
   logic                  desc_push, head_valid, head_pop;
   wmfp_pkg::desc_type    desc, head_desc;
   wmfp_pkg::ssid_wr_type ssid_wr;
   wmfp_pkg::rsp_type     rsp;

   assign full   = q_full;
   assign accept = push && !q_full;

   wmfp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .frame_byte    (req_frame_byte),
      .is_management (req_is_management),
      .signal_level  (req_signal_level),
      .end_of_frame  (req_end_of_frame),
      .wr_slot       (wr_slot),
      .desc          (desc),
      .desc_push     (desc_push),
      .ssid_wr       (ssid_wr)
   );

   wmfp_desc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (desc_push),
      .push_desc  (desc),
      .head_pop   (head_pop),
      .q_full     (q_full),
      .wr_slot    (wr_slot),
      .head_valid (head_valid),
      .rd_slot    (rd_slot),
      .head_desc  (head_desc)
   );

   wmfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .ssid_wr    (ssid_wr),
      .head_valid (head_valid),
      .rd_slot    (rd_slot),
      .head_desc  (head_desc),
      .head_pop   (head_pop),
      .pop        (pop),
      .empty      (empty),
      .rsp        (rsp)
   );

   assign rsp_item_type       = rsp.item_type;
   assign rsp_frame_kind      = rsp.frame_kind;
   assign rsp_station_address = rsp.station_address;
   assign rsp_signal_strength = rsp.signal_strength;
   assign rsp_ssid_length     = rsp.ssid_length;
   assign rsp_ssid_byte       = rsp.ssid_byte;
   assign rsp_last_result     = rsp.last_result;

endmodule
`default_nettype wire

// File: rtl/wmfp_front.sv
`default_nettype none
module wmfp_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [7:0]              frame_byte,
   input  wire logic                    is_management,
   input  wire logic signed [7:0]       signal_level,
   input  wire logic                    end_of_frame,
   input  wire logic                    wr_slot,
   output wmfp_pkg::desc_type           desc,
   output logic                         desc_push,
   output wmfp_pkg::ssid_wr_type        ssid_wr
);

   logic [wmfp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                 fc_ff, fc_in;
   logic [47:0]                addr_ff, addr_in;
   logic [7:0]                 eid_ff, eid_in;
   logic [7:0]                 dlen_ff, dlen_in;
   logic                       ignored_ff, ignored_in;

   logic                       first, ignored, is_probe, is_beacon, has_addr;
   logic [7:0]                 fc;
   logic [wmfp_pkg::POS_W-1:0] addr_at, addr_end, text_ofs;
   logic [wmfp_pkg::POS_W:0]   len;
   logic [wmfp_pkg::POS_W+1:0] ssid_need;
   logic                       len_ok, ssid_ok;

   always_comb begin
      first     = (pos_ff == '0);
      fc        = first ? (frame_byte & wmfp_pkg::FC_MASK) : fc_ff;
      ignored   = first ? !is_management : ignored_ff;
      is_probe  = (fc == wmfp_pkg::FC_PROBE);
      is_beacon = (fc == wmfp_pkg::FC_BEACON);
      has_addr  = is_probe || is_beacon;
      addr_at   = is_probe ? wmfp_pkg::PROBE_ADDR_AT :
                  is_beacon ? wmfp_pkg::BEACON_ADDR_AT : '0;
      addr_end  = addr_at + wmfp_pkg::POS_W'(wmfp_pkg::ADDR_BYTES);

      addr_in = addr_ff;
      for (int k = 0; k < wmfp_pkg::ADDR_BYTES; k++) begin
         if (has_addr && pos_ff == addr_at + wmfp_pkg::POS_W'(k)) begin
            addr_in[8*k +: 8] = frame_byte;
         end
      end

      eid_in  = eid_ff;
      dlen_in = dlen_ff;
      if (is_beacon && pos_ff == wmfp_pkg::SSID_ID_POS) begin
         eid_in = frame_byte;
      end
      if (is_beacon && pos_ff == wmfp_pkg::SSID_LEN_POS) begin
         dlen_in = frame_byte;
      end

      text_ofs      = pos_ff - wmfp_pkg::SSID_TEXT_POS;
      ssid_wr.en    = accept && is_beacon && pos_ff >= wmfp_pkg::SSID_TEXT_POS &&
                      pos_ff < wmfp_pkg::SSID_END_POS;
      ssid_wr.addr  = {wr_slot, text_ofs[wmfp_pkg::SSID_IDX_W-1:0]};
      ssid_wr.data  = frame_byte;

      len       = {1'b0, pos_ff} + (wmfp_pkg::POS_W+1)'(1);
      len_ok    = (len >= {1'b0, addr_end});
      ssid_need = (wmfp_pkg::POS_W+2)'(wmfp_pkg::SSID_ELEMENT_OFFSET + 2) +
                  (wmfp_pkg::POS_W+2)'(dlen_in);
      ssid_ok   = is_beacon &&
                  len > (wmfp_pkg::POS_W+1)'(wmfp_pkg::SSID_ELEMENT_OFFSET + 1) &&
                  eid_in == wmfp_pkg::SSID_ELEMENT_ID && dlen_in != '0 &&
                  dlen_in <= 8'(wmfp_pkg::SSID_MAX_BYTES) &&
                  {1'b0, len} >= ssid_need;

      desc.frame_kind      = is_beacon ? wmfp_pkg::KIND_BEACON : wmfp_pkg::KIND_PROBE;
      desc.station_address = addr_in;
      desc.signal_strength = signal_level;
      desc.ssid_length     = ssid_ok ? dlen_in[wmfp_pkg::LEN_W-1:0] : '0;
      desc_push            = accept && end_of_frame && !ignored && has_addr && len_ok;

      pos_in     = pos_ff;
      fc_in      = fc_ff;
      ignored_in = ignored_ff;
      if (accept) begin
         if (end_of_frame) begin
            // back to the idle frame state
            pos_in     = '0;
            fc_in      = '0;
            ignored_in = 1'b0;
            addr_in    = '0;
            eid_in     = '0;
            dlen_in    = '0;
         end else begin
            pos_in     = (pos_ff == wmfp_pkg::POS_MAX) ? pos_ff :
                         pos_ff + wmfp_pkg::POS_W'(1);
            fc_in      = fc;
            ignored_in = ignored;
         end
      end else begin
         addr_in = addr_ff;
         eid_in  = eid_ff;
         dlen_in = dlen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         fc_ff      <= '0;
         addr_ff    <= '0;
         eid_ff     <= '0;
         dlen_ff    <= '0;
         ignored_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         fc_ff      <= fc_in;
         addr_ff    <= addr_in;
         eid_ff     <= eid_in;
         dlen_ff    <= dlen_in;
         ignored_ff <= ignored_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/wmfp_desc_queue.sv
`default_nettype none
module wmfp_desc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire wmfp_pkg::desc_type push_desc,
   input  wire logic               head_pop,
   output logic                    q_full,
   output logic                    wr_slot,
   output logic                    head_valid,
   output logic                    rd_slot,
   output wmfp_pkg::desc_type      head_desc
);

   wmfp_pkg::desc_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   always_comb begin
      q_full     = (count_ff == 2'd2);
      head_valid = (count_ff != 2'd0);
      wr_slot    = wr_ptr_ff;
      rd_slot    = rd_ptr_ff;
      head_desc  = slot_ff[rd_ptr_ff];
      wr_ptr_in  = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = head_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + 2'(push) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/wmfp_back.sv
`default_nettype none
module wmfp_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wmfp_pkg::ssid_wr_type ssid_wr,
   input  wire logic                  head_valid,
   input  wire logic                  rd_slot,
   input  wire wmfp_pkg::desc_type    head_desc,
   output logic                       head_pop,
   input  wire logic                  pop,
   output logic                       empty,
   output wmfp_pkg::rsp_type          rsp
);

   logic [7:0]                  ssid_mem_ff [wmfp_pkg::MEM_DEPTH];
   logic [7:0]                  rd_data_ff;
   logic [wmfp_pkg::LEN_W-1:0]  idx_ff, idx_in, idx_m1;
   logic                        s1_valid_ff;
   wmfp_pkg::rsp_type           s1_item_ff, s1_item_in, out_wr_item;
   wmfp_pkg::rsp_type           out_buf_ff [wmfp_pkg::OUT_DEPTH];
   logic [wmfp_pkg::OUT_AW-1:0] out_wptr_ff, out_rptr_ff;
   logic [wmfp_pkg::OUT_AW:0]   out_count_ff, out_count_in;
   logic [wmfp_pkg::MEM_AW-1:0] rd_addr;
   logic                        issue, is_desc, last, pop_ok;

   always_comb begin
      // keep room for the item in flight
      issue   = head_valid &&
                (out_count_ff + (wmfp_pkg::OUT_AW+1)'(s1_valid_ff)) <
                (wmfp_pkg::OUT_AW+1)'(wmfp_pkg::OUT_DEPTH);
      is_desc = (idx_ff == '0);
      last    = is_desc ? (head_desc.ssid_length == '0) :
                          (idx_ff == head_desc.ssid_length);
      head_pop = issue && last;
      idx_in   = issue ? (last ? '0 : idx_ff + wmfp_pkg::LEN_W'(1)) : idx_ff;
      idx_m1   = idx_ff - wmfp_pkg::LEN_W'(1);
      rd_addr  = {rd_slot, idx_m1[wmfp_pkg::SSID_IDX_W-1:0]};

      s1_item_in.item_type       = is_desc ? wmfp_pkg::ITEM_DESC : wmfp_pkg::ITEM_SSID;
      s1_item_in.frame_kind      = head_desc.frame_kind;
      s1_item_in.station_address = head_desc.station_address;
      s1_item_in.signal_strength = head_desc.signal_strength;
      s1_item_in.ssid_length     = head_desc.ssid_length;
      s1_item_in.ssid_byte       = '0;
      s1_item_in.last_result     = last;

      out_wr_item = s1_item_ff;
      if (s1_item_ff.item_type == wmfp_pkg::ITEM_SSID) begin
         out_wr_item.ssid_byte = rd_data_ff;
      end

      empty        = (out_count_ff == '0);
      pop_ok       = pop && !empty;
      rsp          = out_buf_ff[out_rptr_ff];
      out_count_in = out_count_ff + (wmfp_pkg::OUT_AW+1)'(s1_valid_ff) -
                     (wmfp_pkg::OUT_AW+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (ssid_wr.en) begin
         ssid_mem_ff[ssid_wr.addr] <= ssid_wr.data;
      end
      rd_data_ff <= ssid_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      if (s1_valid_ff) begin
         out_buf_ff[out_wptr_ff] <= out_wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_wptr_ff  <= '0;
         out_rptr_ff  <= '0;
         out_count_ff <= '0;
      end else begin
         idx_ff       <= idx_in;
         s1_valid_ff  <= issue;
         out_wptr_ff  <= out_wptr_ff + wmfp_pkg::OUT_AW'(s1_valid_ff);
         out_rptr_ff  <= out_rptr_ff + wmfp_pkg::OUT_AW'(pop_ok);
         out_count_ff <= out_count_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/wmfp_checker.sv
`default_nettype none
module wmfp_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop,
   input  wire logic              empty,
   input  wire logic              rsp_item_type,
   input  wire logic              rsp_frame_kind,
   input  wire logic [47:0]       rsp_station_address,
   input  wire logic signed [7:0] rsp_signal_strength,
   input  wire logic [5:0]        rsp_ssid_length,
   input  wire logic [7:0]        rsp_ssid_byte,
   input  wire logic              rsp_last_result
);

   // nothing waits right after reset
   assert property (@(posedge clock) reset |=> empty)
      else $error("result channel not empty after reset");

   // a text beat only follows a descriptor that announced text
   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item_type == wmfp_pkg::ITEM_SSID |-> rsp_ssid_length != '0)
      else $error("SSID beat with zero SSID length");

   // a descriptor without text closes its frame
   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_item_type == wmfp_pkg::ITEM_DESC |->
         rsp_ssid_byte == '0 && (rsp_last_result == (rsp_ssid_length == '0)))
      else $error("descriptor beat with bad text byte or last flag");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_station_address) &&
         $stable(rsp_item_type) && $stable(rsp_ssid_byte) && $stable(rsp_last_result) &&
         $stable(rsp_frame_kind) && $stable(rsp_signal_strength) &&
         $stable(rsp_ssid_length))
      else $error("stalled result changed");

endmodule

bind wifi_mgmt_frame_parser wmfp_checker u_checker (.*);
`default_nettype wire

// File: tb/wifi_mgmt_frame_parser_test.sv
`timescale 1ns / 100ps

module wifi_mgmt_frame_parser_test;

   localparam int STALL_LIMIT  = 2000;
   localparam int PHASE_BYTES  = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 8;

   typedef enum int {
      SENDER_LIGHT,
      RECEIVER_LIGHT,
      NO_IDLE
   } pacing_type;

   typedef struct packed {
      logic [7:0]        data;
      logic              mgmt;
      logic signed [7:0] level;
      logic              eof;
   } capture_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   logic [7:0]        req_frame_byte = '0;
   logic              req_is_management = 1'b0;
   logic signed [7:0] req_signal_level = '0;
   logic              req_end_of_frame = 1'b0;
   logic              pop = 1'b0;
   logic              empty;
   logic              rsp_item_type;
   logic              rsp_frame_kind;
   logic [47:0]       rsp_station_address;
   logic signed [7:0] rsp_signal_strength;
   logic [5:0]        rsp_ssid_length;
   logic [7:0]        rsp_ssid_byte;
   logic              rsp_last_result;

   capture_beat_type   capture_q[$];
   wmfp_pkg::rsp_type  expected_items_q[$];
   pacing_type         pacing = SENDER_LIGHT;
   logic               byte_taken = 1'b0;
   int                 stall_cycles = 0;
   int                 error_count = 0;
   int                 hold_left = 0;
   bit                 hold_done = 1'b0;
   bit                 timed_out = 1'b0;

   // parser state as seen by the predictor
   logic [6:0]  frame_pos = '0;
   logic [7:0]  frame_fc = '0;
   logic [47:0] frame_addr = '0;
   logic [7:0]  elem_id = '0;
   logic [7:0]  elem_len = '0;
   logic [7:0]  ssid_text [wmfp_pkg::SSID_MAX_BYTES];
   logic        frame_dropped = 1'b0;

   wifi_mgmt_frame_parser u_dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_frame_byte      (req_frame_byte),
      .req_is_management   (req_is_management),
      .req_signal_level    (req_signal_level),
      .req_end_of_frame    (req_end_of_frame),
      .pop                 (pop),
      .empty               (empty),
      .rsp_item_type       (rsp_item_type),
      .rsp_frame_kind      (rsp_frame_kind),
      .rsp_station_address (rsp_station_address),
      .rsp_signal_strength (rsp_signal_strength),
      .rsp_ssid_length     (rsp_ssid_length),
      .rsp_ssid_byte       (rsp_ssid_byte),
      .rsp_last_result     (rsp_last_result)
   );

   always #6 clock = ~clock;

   task automatic parse_capture_byte(input logic [7:0] b, input logic mgmt,
                                     input logic signed [7:0] lvl, input logic eof);
      logic [6:0]        addr_at;
      logic [5:0]        ssid_cnt;
      int                flen;
      int                k;
      wmfp_pkg::rsp_type item;
      addr_at  = '0;
      ssid_cnt = '0;
      if (frame_pos == 0) begin
         frame_fc      = b & wmfp_pkg::FC_MASK;
         frame_dropped = !mgmt;
      end
      if (frame_fc == wmfp_pkg::FC_PROBE) addr_at = wmfp_pkg::PROBE_ADDR_AT;
      else if (frame_fc == wmfp_pkg::FC_BEACON) addr_at = wmfp_pkg::BEACON_ADDR_AT;
      if (addr_at != 0 && frame_pos >= addr_at &&
          frame_pos < addr_at + wmfp_pkg::ADDR_BYTES) begin
         k = frame_pos - addr_at;
         frame_addr[8*k +: 8] = b;
      end
      if (frame_fc == wmfp_pkg::FC_BEACON) begin
         if (frame_pos == wmfp_pkg::SSID_ID_POS) elem_id = b;
         else if (frame_pos == wmfp_pkg::SSID_LEN_POS) elem_len = b;
         else if (frame_pos >= wmfp_pkg::SSID_TEXT_POS &&
                  frame_pos < wmfp_pkg::SSID_END_POS)
            ssid_text[frame_pos - wmfp_pkg::SSID_TEXT_POS] = b;
      end
      if (!eof) begin
         if (frame_pos != wmfp_pkg::POS_MAX) frame_pos++;
      end else begin
         flen = frame_pos + 1;
         if (!(frame_dropped || addr_at == 0 || flen < addr_at + wmfp_pkg::ADDR_BYTES)) begin
            if (frame_fc == wmfp_pkg::FC_BEACON &&
                flen > wmfp_pkg::SSID_ELEMENT_OFFSET + 1 &&
                elem_id == wmfp_pkg::SSID_ELEMENT_ID && elem_len > 0 &&
                elem_len <= wmfp_pkg::SSID_MAX_BYTES &&
                flen >= wmfp_pkg::SSID_ELEMENT_OFFSET + 2 + elem_len)
               ssid_cnt = elem_len[5:0];
            item.item_type       = wmfp_pkg::ITEM_DESC;
            item.frame_kind      = (frame_fc == wmfp_pkg::FC_BEACON) ?
                                   wmfp_pkg::KIND_BEACON : wmfp_pkg::KIND_PROBE;
            item.station_address = frame_addr;
            item.signal_strength = lvl;
            item.ssid_length     = ssid_cnt;
            item.ssid_byte       = '0;
            item.last_result     = (ssid_cnt == 0);
            expected_items_q.push_back(item);
            for (int i = 0; i < ssid_cnt; i++) begin
               item.item_type   = wmfp_pkg::ITEM_SSID;
               item.ssid_byte   = ssid_text[i];
               item.last_result = (i + 1 == ssid_cnt);
               expected_items_q.push_back(item);
            end
         end
         frame_pos     = '0;
         frame_fc      = '0;
         frame_addr    = '0;
         elem_id       = '0;
         elem_len      = '0;
         frame_dropped = 1'b0;
      end
   endtask

   task automatic check_result_item();
      wmfp_pkg::rsp_type want;
      if (expected_items_q.size() == 0) begin
         $error("result beat with nothing expected: item_type %0d ssid_byte %h",
                rsp_item_type, rsp_ssid_byte);
         error_count++;
      end else begin
         want = expected_items_q.pop_front();
         if (rsp_item_type !== want.item_type) begin
            $error("item_type: expected %0d, got %0d", want.item_type, rsp_item_type);
            error_count++;
         end
         if (rsp_frame_kind !== want.frame_kind) begin
            $error("frame_kind: expected %0d, got %0d", want.frame_kind, rsp_frame_kind);
            error_count++;
         end
         if (rsp_station_address !== want.station_address) begin
            $error("station_address: expected %h, got %h",
                   want.station_address, rsp_station_address);
            error_count++;
         end
         if (rsp_signal_strength !== want.signal_strength) begin
            $error("signal_strength: expected %0d, got %0d",
                   want.signal_strength, rsp_signal_strength);
            error_count++;
         end
         if (rsp_ssid_length !== want.ssid_length) begin
            $error("ssid_length: expected %0d, got %0d", want.ssid_length, rsp_ssid_length);
            error_count++;
         end
         if (rsp_ssid_byte !== want.ssid_byte) begin
            $error("ssid_byte: expected %h, got %h", want.ssid_byte, rsp_ssid_byte);
            error_count++;
         end
         if (rsp_last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d", want.last_result, rsp_last_result);
            error_count++;
         end
      end
   endtask

   // sample both handshakes at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         byte_taken   <= 1'b0;
         stall_cycles <= 0;
      end else begin
         byte_taken <= push && !full;
         if (push && !full) begin
            parse_capture_byte(req_frame_byte, req_is_management, req_signal_level,
                               req_end_of_frame);
            void'(capture_q.pop_front());
         end
         if (pop && !empty) check_result_item();
         stall_cycles <= ((push && !full) || (pop && !empty)) ? 0 : stall_cycles + 1;
      end
   end

   // sender: hold an offered beat until it is taken
   always @(negedge clock) begin
      if (reset || capture_q.size() == 0) begin
         push <= 1'b0;
      end else if (!(push && !byte_taken)) begin
         if ($urandom_range(0, 99) >= (pacing == SENDER_LIGHT   ? 11 :
                                       pacing == RECEIVER_LIGHT ? 76 : 0)) begin
            push              <= 1'b1;
            req_frame_byte    <= capture_q[0].data;
            req_is_management <= capture_q[0].mgmt;
            req_signal_level  <= capture_q[0].level;
            req_end_of_frame  <= capture_q[0].eof;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver: one long hold-off in the unpaced phase backs the block up
   always @(negedge clock) begin
      if (hold_left != 0) begin
         pop       <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && pacing == NO_IDLE && capture_q.size() > 60) begin
         pop       <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         pop <= ($urandom_range(0, 99) >= (pacing == SENDER_LIGHT   ? 76 :
                                           pacing == RECEIVER_LIGHT ? 11 : 0));
      end
   end

   // id, slen and fill below zero leave those bytes random
   task automatic queue_frame(input logic [7:0] fc, input logic mgmt, input int flen,
                              input logic signed [7:0] lvl, input int id, input int slen,
                              input int fill);
      capture_beat_type beat;
      for (int p = 0; p < flen; p++) begin
         beat.data = (fill < 0) ? 8'($urandom) : 8'(fill);
         if (p == 0) beat.data = fc;
         else if (p == wmfp_pkg::SSID_ELEMENT_OFFSET && id >= 0) beat.data = 8'(id);
         else if (p == wmfp_pkg::SSID_ELEMENT_OFFSET + 1 && slen >= 0) beat.data = 8'(slen);
         beat.mgmt  = (p == 0) ? mgmt : 1'($urandom);
         beat.level = (p == flen - 1) ? lvl : 8'($urandom);
         beat.eof   = (p == flen - 1);
         capture_q.push_back(beat);
      end
   endtask

   task automatic queue_random_frame(output int flen);
      int         pick;
      int         slen;
      logic [7:0] low_bits;
      logic [7:0] lvl;
      pick     = $urandom_range(0, 99);
      low_bits = 8'($urandom_range(0, 3));
      lvl      = 8'($urandom);
      if (pick < 40) begin
         slen = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8);
         flen = wmfp_pkg::SSID_ELEMENT_OFFSET + 2 + slen + $urandom_range(0, 3);
         queue_frame(wmfp_pkg::FC_BEACON | low_bits, 1'b1, flen, lvl,
                     wmfp_pkg::SSID_ELEMENT_ID, slen, -1);
      end else if (pick < 65) begin
         flen = $urandom_range(16, 30);
         queue_frame(wmfp_pkg::FC_PROBE | low_bits, 1'b1, flen, lvl, -1, -1, -1);
      end else if (pick < 75) begin
         // broken or truncated SSID element
         flen = $urandom_range(22, 45);
         queue_frame(wmfp_pkg::FC_BEACON | low_bits, 1'b1, flen, lvl,
                     ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) :
                                                   wmfp_pkg::SSID_ELEMENT_ID,
                     $urandom_range(0, 40), -1);
      end else if (pick < 85) begin
         flen = $urandom_range(16, 40);
         queue_frame(($urandom_range(0, 1) == 0) ? 8'($urandom) :
                     ($urandom_range(0, 1) == 0) ? wmfp_pkg::FC_PROBE : wmfp_pkg::FC_BEACON,
                     1'($urandom), flen, lvl, -1, -1, -1);
      end else if (pick < 93) begin
         flen = $urandom_range(1, 21);
         queue_frame(($urandom_range(0, 1) == 0) ? wmfp_pkg::FC_PROBE : wmfp_pkg::FC_BEACON,
                     1'b1, flen, lvl, -1, -1, -1);
      end else begin
         flen = $urandom_range(100, 140);
         queue_frame(wmfp_pkg::FC_BEACON, 1'b1, flen, lvl, wmfp_pkg::SSID_ELEMENT_ID,
                     $urandom_range(1, 32), -1);
      end
   endtask

   task automatic wait_drained();
      while (capture_q.size() != 0 || expected_items_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_random_phase(input pacing_type mode, input int budget);
      int added;
      int flen;
      added  = 0;
      pacing = mode;
      while (added < budget) begin
         queue_random_frame(flen);
         added += flen;
      end
      wait_drained();
   endtask

   task automatic run_all();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // single byte, not management, other type, short and exact address, no SSID text
      queue_frame(wmfp_pkg::FC_PROBE, 1'b1, 1, 8'sd0, -1, -1, -1);
      queue_frame(wmfp_pkg::FC_PROBE, 1'b0, 16, 8'sd5, -1, -1, -1);
      queue_frame(8'hB0, 1'b1, 16, 8'sd1, -1, -1, -1);
      queue_frame(wmfp_pkg::FC_PROBE, 1'b1, 15, -8'sd3, -1, -1, -1);
      queue_frame(wmfp_pkg::FC_PROBE | 8'h03, 1'b1, 16, -8'sd128, -1, -1, 8'hFF);
      queue_frame(wmfp_pkg::FC_BEACON, 1'b1, 21, -8'sd60, -1, -1, -1);
      queue_frame(wmfp_pkg::FC_BEACON, 1'b1, 22, 8'sd127, -1, -1, 8'h00);
      queue_frame(wmfp_pkg::FC_BEACON, 1'b1, 38, -8'sd63, wmfp_pkg::SSID_ELEMENT_ID, 0, -1);
      wait_drained();

      run_random_phase(RECEIVER_LIGHT, PHASE_BYTES);
      // a long beacon with a full SSID and then an exact one, so the hold-off
      // backs the block up to its input
      queue_frame(wmfp_pkg::FC_BEACON | 8'h03, 1'b1, 130, -8'sd66,
                  wmfp_pkg::SSID_ELEMENT_ID, 32, -1);
      queue_frame(wmfp_pkg::FC_BEACON, 1'b1, 39, -8'sd64, wmfp_pkg::SSID_ELEMENT_ID, 1, -1);
      run_random_phase(NO_IDLE, 1);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      fork
         run_all();
         wait (stall_cycles >= STALL_LIMIT);
      join_any
      timed_out = (stall_cycles >= STALL_LIMIT);
      if (timed_out || error_count != 0 || expected_items_q.size() != 0) begin
         $display("wifi_mgmt_frame_parser_test: errors");
      end else begin
         $display("wifi_mgmt_frame_parser_test: clean");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/wmfp_pkg.sv
rtl/wmfp_front.sv
rtl/wmfp_desc_queue.sv
rtl/wmfp_back.sv
rtl/wifi_mgmt_frame_parser.sv
rtl/wmfp_checker.sv
tb/wifi_mgmt_frame_parser_test.sv
